[hdl/pdc_pkg.sv]
// Package for the pixel depth converter: configuration record, codes and
// the float32 / half packing helpers. It depends on nothing else.
package pdc_pkg;

    localparam int CfgIdxW = 3;
    localparam int DataW   = 32;

    localparam logic [CfgIdxW-1:0] REG_CONV_KIND    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_IN_IS_WORD   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OUT_IS_WORD  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SHIFT_AMOUNT = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SCALE_BITS   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OFFSET_BITS  = 3'd5;

    localparam logic [2:0] KIND_SHIFT      = 3'd0;
    localparam logic [2:0] KIND_INT_HALF   = 3'd1;
    localparam logic [2:0] KIND_INT_FLOAT  = 3'd2;
    localparam logic [2:0] KIND_HALF_FLOAT = 3'd3;
    localparam logic [2:0] KIND_FLOAT_HALF = 3'd4;

    localparam logic [31:0] F32_QNAN   = 32'h7FC0_0000;
    localparam logic [31:0] F32_ONE    = 32'h3F80_0000;
    localparam logic [3:0]  SHIFT_MAX  = 4'd15;

    typedef struct packed {
        logic [2:0]  conv_kind;
        logic        in_is_word;
        logic        out_is_word;
        logic [3:0]  shift_amount;
        logic [31:0] scale_bits;
        logic [31:0] offset_bits;
    } pdc_cfg_t;

    // Leading zero count of a 40-bit word (40 when the word is zero).
    function automatic logic [5:0] lzc40(input logic [39:0] v);
        logic [5:0] n;
        n = 6'd40;
        for (int i = 0; i < 40; i++) begin
            if (v[i]) n = 6'(39 - i);
        end
        return n;
    endfunction

    // Leading zero count of a 28-bit word.
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    // Rounds a normalized magnitude to float32, nearest even. m[26] is the
    // leading one, m[25:3] the fraction, m[2:0] guard bits; eb is the biased
    // exponent, which may fall below one (subnormal) or reach 255 (overflow).
    function automatic logic [31:0] f32_round_pack(input logic sign,
                                                   input logic signed [9:0] eb,
                                                   input logic [26:0] m,
                                                   input logic sticky);
        logic [9:0]  sh;
        logic [26:0] ms;
        logic        st;
        logic [7:0]  ef;
        logic [30:0] mag;
        logic        rnd;
        sh = '0;
        ms = m;
        st = sticky;
        ef = '0;
        if (eb >= 10'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        if (eb <= 10'sd0) begin
            sh = 10'd1 - $unsigned(eb);
            if (sh >= 10'd27) begin
                ms = '0;
                st = sticky | (|m);
            end else begin
                ms = m >> sh[4:0];
                st = sticky | (|(m & ((27'd1 << sh[4:0]) - 27'd1)));
            end
        end else begin
            ef = eb[7:0];
        end
        mag = {ef, ms[25:3]};
        rnd = ms[2] & ((|ms[1:0]) | st | ms[3]);
        return {sign, mag + 31'(rnd)};
    endfunction

    // Float32 to half, nearest even; NaN keeps the top payload bits.
    function automatic logic [15:0] f32_to_half(input logic [31:0] f);
        logic               s;
        logic [7:0]         e;
        logic [22:0]        m;
        logic signed [9:0]  ex;
        logic [23:0]        mm;
        logic [4:0]         sh;
        logic [23:0]        res;
        logic               g;
        logic               st;
        logic [14:0]        nres;
        s  = f[31];
        e  = f[30:23];
        m  = f[22:0];
        ex = $signed({2'b00, e}) - 10'sd112;
        mm = {1'b1, m};
        sh = '0;
        res = '0;
        g = 1'b0;
        st = 1'b0;
        nres = '0;
        if (e == 8'hFF) begin
            if (m != '0) return {s, 5'h1F, 1'b1, m[21:13]};
            return {s, 15'h7C00};
        end
        if (ex >= 10'sd31) return {s, 15'h7C00};
        if (ex <= 10'sd0) begin
            if (ex < -10'sd10) return {s, 15'd0};
            sh  = 5'(10'sd14 - ex);
            res = mm >> sh;
            g   = mm[sh - 5'd1];
            st  = |(mm & ((24'd1 << (sh - 5'd1)) - 24'd1));
            res = res + 24'(g & (st | res[0]));
            return {s, res[14:0]};
        end
        nres = {ex[4:0], m[22:13]};
        g    = m[12];
        st   = |m[11:0];
        return {s, nres + 15'(g & (st | nres[0]))};
    endfunction

    // Half to float32, exact; NaN comes out quiet.
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic       s;
        logic [4:0] e;
        logic [9:0] m;
        logic [3:0] shift;
        logic [9:0] mn;
        s = h[15];
        e = h[14:10];
        m = h[9:0];
        shift = '0;
        if (e == 5'h1F) begin
            if (m != '0) return {s, 8'hFF, 1'b1, m[8:0], 13'd0};
            return {s, 8'hFF, 23'd0};
        end
        if (e == 5'd0) begin
            if (m == '0) return {s, 31'd0};
            for (int i = 0; i < 10; i++) begin
                if (m[i]) shift = 4'(10 - i);
            end
            mn = m << shift;
            return {s, 8'd113 - 8'(shift), mn, 13'd0};
        end
        return {s, 8'({3'b000, e}) + 8'd112, m, 13'd0};
    endfunction

endpackage

[hdl/pdc_mul.sv]
// Integer sample times float32 scale, two pipeline stages: the raw
// mantissa product, then normalize and round. Depends on pdc_pkg.
module pdc_mul
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  pdc_cfg_t    cfg,
    input  logic [31:0] sample,
    output logic [31:0] prod
);

    logic [15:0] x;
    logic [23:0] sc_man;
    logic [39:0] p_reg;
    logic [7:0]  e_reg;
    logic        xz_reg;
    logic [5:0]  lz;
    logic [39:0] pn;
    logic signed [9:0] eb;
    logic        sc_sign;
    logic        sc_nan;
    logic        sc_inf;
    logic [31:0] prod_next;
    logic [31:0] prod_reg;

    assign x       = cfg.in_is_word ? sample[15:0] : {8'h00, sample[7:0]};
    assign sc_man  = {(cfg.scale_bits[30:23] != 8'd0), cfg.scale_bits[22:0]};
    assign sc_sign = cfg.scale_bits[31];
    assign sc_nan  = (cfg.scale_bits[30:23] == 8'hFF) && (cfg.scale_bits[22:0] != '0);
    assign sc_inf  = (cfg.scale_bits[30:23] == 8'hFF) && (cfg.scale_bits[22:0] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= 40'(x) * 40'(sc_man);
            e_reg  <= (cfg.scale_bits[30:23] == 8'd0) ? 8'd1 : cfg.scale_bits[30:23];
            xz_reg <= (x == '0);
        end
    end

    assign lz = lzc40(p_reg);
    assign pn = p_reg << lz;
    assign eb = $signed({2'b00, e_reg}) + 10'sd16 - $signed({4'b0000, lz});

    always_comb
    begin
        if (sc_nan)
            prod_next = F32_QNAN;
        else if (sc_inf)
            prod_next = xz_reg ? F32_QNAN : {sc_sign, 8'hFF, 23'd0};
        else if (p_reg == '0)
            prod_next = {sc_sign, 31'd0};
        else
            prod_next = f32_round_pack(sc_sign, eb, pn[39:13], |pn[12:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[hdl/pdc_add.sv]
// Float32 addition of the scaled sample and the offset, two stages:
// align and add, then normalize and round. Depends on pdc_pkg.
module pdc_add
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);

    logic        nan_a, nan_b, inf_a, inf_b;
    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, d;
    logic [26:0] m_big, m_sml, sh_sml, aligned;
    logic        st;
    logic [27:0] s_next;
    logic        spec_next;
    logic [31:0] spec_val_next;

    logic [27:0] s_reg;
    logic [7:0]  e_reg;
    logic        sign_reg;
    logic        zsign_reg;
    logic        spec_reg;
    logic [31:0] spec_val_reg;

    logic [4:0]  lz;
    logic [27:0] sn;
    logic signed [9:0] eb;
    logic [31:0] sum_next;
    logic [31:0] sum_reg;

    assign nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    assign nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    assign inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    assign inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);

    assign swap  = b[30:0] > a[30:0];
    assign big   = swap ? b : a;
    assign sml   = swap ? a : b;
    assign e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    assign e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    assign d     = e_big - e_sml;
    assign m_big = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    assign m_sml = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};

    always_comb
    begin
        if (d >= 8'd27)
        begin
            sh_sml = '0;
            st     = |m_sml;
        end
        else
        begin
            sh_sml = m_sml >> d[4:0];
            st     = |(m_sml & ((27'd1 << d[4:0]) - 27'd1));
        end
        aligned = {sh_sml[26:1], sh_sml[0] | st};
        if (a[31] ^ b[31])
            s_next = {1'b0, m_big} - {1'b0, aligned};
        else
            s_next = {1'b0, m_big} + {1'b0, aligned};

        spec_next     = 1'b1;
        spec_val_next = F32_QNAN;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
            spec_val_next = F32_QNAN;
        else if (inf_a)
            spec_val_next = a;
        else if (inf_b)
            spec_val_next = b;
        else
            spec_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg        <= s_next;
            e_reg        <= e_big;
            sign_reg     <= big[31];
            zsign_reg    <= a[31] & b[31];
            spec_reg     <= spec_next;
            spec_val_reg <= spec_val_next;
        end
    end

    assign lz = lzc28(s_reg);
    assign sn = s_reg << lz;
    assign eb = $signed({2'b00, e_reg}) + 10'sd1 - $signed({5'b00000, lz});

    always_comb
    begin
        if (spec_reg)
            sum_next = spec_val_reg;
        else if (s_reg == '0)
            sum_next = {zsign_reg, 31'd0};   // exact cancellation gives +0
        else
            sum_next = f32_round_pack(sign_reg, eb, sn[27:1], sn[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

[hdl/pdc_fmt.sv]
// Output formatting stage: integer shift, half narrowing and widening,
// and selection by conversion kind into the result register. Depends on pdc_pkg.
module pdc_fmt
    import pdc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  pdc_cfg_t    cfg,
    input  logic [31:0] sample,
    input  logic [31:0] sum,
    output logic [31:0] result
);

    logic [15:0] ival;
    logic [30:0] shifted;
    logic [15:0] narrow_q;
    logic [31:0] res_next;
    logic [31:0] res_reg;

    assign ival     = cfg.in_is_word ? sample[15:0] : {8'h00, sample[7:0]};
    assign shifted  = 31'(ival) << cfg.shift_amount;
    // One narrowing unit serves both the int-to-half and float-to-half kinds.
    assign narrow_q = f32_to_half((cfg.conv_kind == KIND_INT_HALF) ? sum : sample);

    always_comb
    begin
        unique case (cfg.conv_kind)
            KIND_SHIFT:
                res_next = cfg.out_is_word ? {16'h0000, shifted[15:0]}
                                           : {24'h000000, shifted[7:0]};
            KIND_INT_HALF:   res_next = {16'h0000, narrow_q};
            KIND_INT_FLOAT:  res_next = sum;
            KIND_HALF_FLOAT: res_next = half_to_f32(sample[15:0]);
            KIND_FLOAT_HALF: res_next = {16'h0000, narrow_q};
            default:         res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

[hdl/pixel_depth_converter.sv]
// Top level of the pixel depth converter: configuration registers, stream
// ports and the six-stage pipeline. Depends on pdc_pkg, pdc_mul, pdc_add, pdc_fmt.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata = sample, s_tlast = row_end_in
//  m_*       out        m_tvalid/m_tready   m_tdata = converted, m_tlast = row_end_out
//  cfg_*     in         cfg_valid/cfg_ready cfg_index = register, cfg_data = value
//
// One beat is accepted every cycle while the output is not stalled; each beat
// passes in order through the input register, product, product rounding,
// alignment and add, sum rounding and output register.
// Reset clears the stage valid bits and loads the configuration defaults.
// When the output register holds a beat that is not taken, the whole pipeline
// freezes and s_tready falls in the same cycle; no beat is dropped.
// Configuration writes are always taken (cfg_ready is tied high).
module pixel_depth_converter
    import pdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,    // [31:0] sample
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,    // [31:0] converted
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int Stages = 6;

    pdc_cfg_t cfg_reg;
    logic     en;
    logic [Stages-1:0] valid_reg;
    logic [31:0] sample_reg [0:Stages-2];
    logic        last_reg   [0:Stages-1];
    logic [31:0] prod;
    logic [31:0] sum;
    logic [31:0] result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conv_kind    <= KIND_INT_FLOAT;
            cfg_reg.in_is_word   <= 1'b0;
            cfg_reg.out_is_word  <= 1'b0;
            cfg_reg.shift_amount <= '0;
            cfg_reg.scale_bits   <= F32_ONE;
            cfg_reg.offset_bits  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CONV_KIND:    cfg_reg.conv_kind    <= cfg_data[2:0];
                REG_IN_IS_WORD:   cfg_reg.in_is_word   <= cfg_data[0];
                REG_OUT_IS_WORD:  cfg_reg.out_is_word  <= cfg_data[0];
                REG_SHIFT_AMOUNT: cfg_reg.shift_amount <= cfg_data[3:0] & SHIFT_MAX;
                REG_SCALE_BITS:   cfg_reg.scale_bits   <= cfg_data;
                REG_OFFSET_BITS:  cfg_reg.offset_bits  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register is free or drained.
    assign en       = !valid_reg[Stages-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[Stages-2:0], s_tvalid};
    end

    // Sample and row-end mark travel beside the arithmetic.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg[0] <= s_tdata;
            last_reg[0]   <= s_tlast;
            for (int i = 1; i < Stages - 1; i++)
                sample_reg[i] <= sample_reg[i-1];
            for (int i = 1; i < Stages; i++)
                last_reg[i] <= last_reg[i-1];
        end
    end

    pdc_mul u_mul (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg_reg),
        .sample (sample_reg[0]),
        .prod   (prod)
    );

    pdc_add u_add (
        .clk (clk),
        .en  (en),
        .a   (prod),
        .b   (cfg_reg.offset_bits),
        .sum (sum)
    );

    pdc_fmt u_fmt (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg_reg),
        .sample (sample_reg[Stages-2]),
        .sum    (sum),
        .result (result)
    );

    assign m_tvalid = valid_reg[Stages-1];
    assign m_tdata  = result;
    assign m_tlast  = last_reg[Stages-1];

    // Input is taken exactly when the pipeline advances.
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // An advancing pipeline moves the fifth stage valid into the output.
    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (valid_reg[Stages-1] == $past(valid_reg[Stages-2])))
        else $error("output valid lost or invented");

    // A new output beat always came from the stage before.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(valid_reg[Stages-2]))
        else $error("output beat without a source");

endmodule
